### rtl/core/pcfd_pkg.sv
// Shared constants, types and control structs of the per-class first-free dispatcher.
package pcfd_pkg;

  // Sizing
  localparam int MAX_SERVERS = 16;
  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_CLASSES = 3;

  // Fixed field widths
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int TAG_W     = 16;
  localparam int CLS_W     = 2;
  localparam int SRV_OUT_W = 4;
  localparam int ACT_W     = 5;
  localparam logic [ACT_W-1:0] ACT_RESET = 5'd10;

  // Derived widths
  localparam int SRV_IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int SRV_CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int CLS_IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int ENTRY_W   = DUR_W + TAG_W;

  // Operation and result codes
  localparam logic OP_ENQ     = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam logic RES_ACK    = 1'b0;
  localparam logic RES_REPORT = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_START,
    ST_SCAN,
    ST_FIN,
    ST_EMIT
  } state_e;

  // Queue bank control and status
  typedef struct packed {
    logic                 push;
    logic                 pop;
    logic                 rd;
    logic [CLS_IDX_W-1:0] cls;
    logic [ENTRY_W-1:0]   wdata;
  } q_ctrl_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [ENTRY_W-1:0] head;
  } q_stat_t;

  // Server table control
  typedef struct packed {
    logic                 wr;
    logic [SRV_IDX_W-1:0] idx;
    logic [TIME_W-1:0]    fin;
    logic                 adv;
  } srv_ctrl_t;

endpackage

### rtl/core/pcfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcfd_ram #(
  parameter int Width = 32,
  parameter int Depth = 192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pcfd_queues.sv
// Per-class request queues: pointers and counts in flops, entries in one shared RAM.
module pcfd_queues import pcfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_ctrl_t ctrl_i,
  output q_stat_t stat_o
);

  logic [PTR_W-1:0]     head_q  [NUM_CLASSES];
  logic [PTR_W-1:0]     tail_q  [NUM_CLASSES];
  logic [CNT_W-1:0]     count_q [NUM_CLASSES];
  logic                 cls_ok;
  logic [CLS_IDX_W-1:0] cls;
  logic [PTR_W-1:0]     head_sel;
  logic [PTR_W-1:0]     tail_sel;
  logic [CNT_W-1:0]     count_sel;
  logic [RAM_AW-1:0]    waddr;
  logic [RAM_AW-1:0]    raddr;
  logic [ENTRY_W-1:0]   rdata;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Class select, guarded against codes beyond the last class
  assign cls_ok    = (32'(ctrl_i.cls) < NUM_CLASSES);
  assign cls       = cls_ok ? ctrl_i.cls : '0;
  assign head_sel  = head_q[cls];
  assign tail_sel  = tail_q[cls];
  assign count_sel = count_q[cls];

  // Pointer and count update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (cls_ok) begin
      if (ctrl_i.push) begin
        tail_q[cls]  <= next_ptr(tail_sel);
        count_q[cls] <= count_sel + CNT_W'(1);
      end else if (ctrl_i.pop) begin
        head_q[cls]  <= next_ptr(head_sel);
        count_q[cls] <= count_sel - CNT_W'(1);
      end
    end
  end

  // Entry addresses: class base plus pointer
  assign waddr = RAM_AW'(32'(cls) * QUEUE_DEPTH + 32'(tail_sel));
  assign raddr = RAM_AW'(32'(cls) * QUEUE_DEPTH + 32'(head_sel));

  pcfd_ram #(
    .Width (ENTRY_W),
    .Depth (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push && cls_ok),
    .waddr_i (waddr),
    .wdata_i (ctrl_i.wdata),
    .re_i    (ctrl_i.rd && cls_ok),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign stat_o.empty = !cls_ok || (count_sel == '0);
  assign stat_o.full  = !cls_ok || (count_sel == CNT_W'(QUEUE_DEPTH));
  assign stat_o.head  = rdata;

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> !stat_o.full)
    else $error("push into a full or invalid queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> !stat_o.empty)
    else $error("pop from an empty queue");

  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && ctrl_i.pop))
    else $error("push and pop in the same cycle");

endmodule

### rtl/core/pcfd_servers.sv
// Server finish-time table, tick counter and the shared free-check comparator.
module pcfd_servers import pcfd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srv_ctrl_t            ctrl_i,
  input  logic [SRV_IDX_W-1:0] scan_idx_i,
  input  logic [DUR_W-1:0]     dur_i,
  output logic                 free_o,
  output logic [TIME_W-1:0]    fin_o
);

  logic [TIME_W-1:0] finish_q [MAX_SERVERS];
  logic [TIME_W-1:0] now_q;
  logic [TIME_W:0]   sum;
  logic [TIME_W:0]   sum_m1;

  // One compare per cycle against the server under scan
  assign free_o = (finish_q[scan_idx_i] <= now_q);

  // now + duration - 1, floored at zero and clamped at the top of the range
  assign sum    = {1'b0, now_q} + (TIME_W + 1)'(dur_i);
  assign sum_m1 = sum - (TIME_W + 1)'(1);
  always_comb begin
    if (sum == '0) begin
      fin_o = '0;
    end else if (sum_m1[TIME_W]) begin
      fin_o = '1;
    end else begin
      fin_o = sum_m1[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
        finish_q[i] <= '0;
      end
      now_q <= '0;
    end else begin
      if (ctrl_i.wr) begin
        finish_q[ctrl_i.idx] <= ctrl_i.fin;
      end
      // Time saturates at its maximum
      if (ctrl_i.adv && (now_q != '1)) begin
        now_q <= now_q + TIME_W'(1);
      end
    end
  end

  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    now_q >= $past(now_q))
    else $error("tick counter went backwards");

  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr |-> (finish_q[ctrl_i.idx] <= now_q))
    else $error("busy server reassigned");

  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.adv && (now_q != '1) |=> (now_q == $past(now_q) + TIME_W'(1)))
    else $error("tick counter did not advance");

endmodule

### rtl/core/per_class_first_free_dispatch.sv
// Top level: sequencer, input latch and output register of the per-class dispatcher.
//
// Input channel (in_valid_i / in_stall_o) carries one word: an enqueue of a
// request into its class queue, or one dispatch tick. Output channel
// (out_valid_o / out_stall_i) returns one acknowledgement per enqueue and one
// report per class per tick, the final one flagged by last_o.
// The block takes one input word at a time; in_stall_o is low only while the
// sequencer is idle, even if the output register still holds an untaken word.
// Enqueue: ST_ENQ loads the acknowledgement into the output register once it is free.
// Tick: per class, ST_START reads the queue head; an empty queue goes straight to ST_EMIT,
// else ST_SCAN runs until server k is free (then ST_FIN computes its finish time) or all
// N active servers are found busy, then ST_EMIT. The single finish-time comparator checks
// one server per cycle in ascending order; the queue head comes from one RAM read.
// Reset clears queue pointers, counts, all finish times, the tick counter and
// sets active_servers to 10; queue storage itself is not cleared.
// When the receiver stalls, the result word holds in the output register and
// the sequencer waits before producing the next one; nothing is dropped.
// Write active_servers via cfg_we_i/cfg_wdata_i only while idle; the block does not check.
module per_class_first_free_dispatch import pcfd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ACT_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [CLS_W-1:0]     job_type_i,
  input  logic [DUR_W-1:0]     duration_i,
  input  logic [TAG_W-1:0]     request_tag_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 result_kind_o,
  output logic                 accepted_o,
  output logic                 dispatched_o,
  output logic [CLS_W-1:0]     class_index_o,
  output logic [SRV_OUT_W-1:0] server_index_o,
  output logic [TAG_W-1:0]     dispatched_tag_o,
  output logic [TIME_W-1:0]    finish_time_o,
  output logic                 last_o
);

  state_e state_q, state_d;

  logic [ACT_W-1:0]     active_q;
  logic [CLS_W-1:0]     job_q;
  logic [DUR_W-1:0]     dur_q;
  logic [TAG_W-1:0]     tag_q;
  logic [CLS_IDX_W-1:0] cls_q, cls_d;
  logic [SRV_CNT_W-1:0] srv_q, srv_d;
  logic                 disp_q, disp_d;
  logic [TIME_W-1:0]    fin_q, fin_d;

  logic                 out_valid_q;
  logic                 res_kind_q, res_kind_d;
  logic                 res_acc_q, res_acc_d;
  logic                 res_disp_q, res_disp_d;
  logic [CLS_W-1:0]     res_cls_q, res_cls_d;
  logic [SRV_OUT_W-1:0] res_srv_q, res_srv_d;
  logic [TAG_W-1:0]     res_tag_q, res_tag_d;
  logic [TIME_W-1:0]    res_fin_q, res_fin_d;
  logic                 res_last_q, res_last_d;
  logic                 out_load;

  logic                 in_acc;
  logic                 slot_free;
  logic                 last_cls;
  logic                 job_ok;
  logic                 scan_end;
  logic [31:0]          act_ext;
  logic [SRV_CNT_W-1:0] nsrv;
  logic                 srv_free;
  logic [TIME_W-1:0]    fin_calc;

  q_ctrl_t   q_ctrl;
  q_stat_t   q_stat;
  srv_ctrl_t srv_ctrl;

  // Handshake and simple decodes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign last_cls   = (cls_q == CLS_IDX_W'(NUM_CLASSES - 1));
  assign job_ok     = (32'(job_q) < NUM_CLASSES);

  // Active server count, saturated to the table size
  assign act_ext  = 32'(active_q);
  assign nsrv     = (act_ext > 32'(MAX_SERVERS)) ? SRV_CNT_W'(MAX_SERVERS)
                                                 : SRV_CNT_W'(act_ext);
  assign scan_end = (srv_q >= nsrv);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACT_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // Input word latch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      job_q <= job_type_i;
      dur_q <= duration_i;
      tag_q <= request_tag_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (operation_i == OP_TICK) ? ST_START : ST_ENQ;
        end
      end
      ST_ENQ: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_START: begin
        state_d = q_stat.empty ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_EMIT;
        end else if (srv_free) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = last_cls ? ST_IDLE : ST_START;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs and datapath next values
  always_comb begin
    q_ctrl       = '0;
    q_ctrl.cls   = (state_q == ST_ENQ) ? CLS_IDX_W'(job_q) : cls_q;
    q_ctrl.wdata = {dur_q, tag_q};
    srv_ctrl     = '0;
    srv_ctrl.idx = srv_q[SRV_IDX_W-1:0];
    srv_ctrl.fin = fin_q;
    cls_d        = cls_q;
    srv_d        = srv_q;
    disp_d       = disp_q;
    fin_d        = fin_q;
    out_load     = 1'b0;
    res_kind_d   = RES_REPORT;
    res_acc_d    = 1'b0;
    res_disp_d   = 1'b0;
    res_cls_d    = CLS_W'(cls_q);
    res_srv_d    = '0;
    res_tag_d    = '0;
    res_fin_d    = '0;
    res_last_d   = last_cls;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (operation_i == OP_TICK)) begin
          cls_d = '0;
        end
      end
      ST_ENQ: begin
        res_kind_d = RES_ACK;
        res_acc_d  = job_ok && !q_stat.full;
        res_cls_d  = job_q;
        res_tag_d  = tag_q;
        res_last_d = 1'b1;
        if (slot_free) begin
          out_load    = 1'b1;
          q_ctrl.push = job_ok && !q_stat.full;
        end
      end
      ST_START: begin
        disp_d    = 1'b0;
        srv_d     = '0;
        q_ctrl.rd = !q_stat.empty;
      end
      ST_SCAN: begin
        if (!scan_end && !srv_free) begin
          srv_d = srv_q + SRV_CNT_W'(1);
        end
      end
      ST_FIN: begin
        fin_d  = fin_calc;
        disp_d = 1'b1;
      end
      ST_EMIT: begin
        if (disp_q) begin
          res_disp_d = 1'b1;
          res_srv_d  = SRV_OUT_W'(srv_q);
          res_tag_d  = q_stat.head[TAG_W-1:0];
          res_fin_d  = fin_q;
        end
        if (slot_free) begin
          out_load     = 1'b1;
          srv_ctrl.wr  = disp_q;
          q_ctrl.pop   = disp_q;
          srv_ctrl.adv = last_cls;
          if (!last_cls) begin
            cls_d = cls_q + CLS_IDX_W'(1);
          end
        end
      end
      default: begin
        cls_d = cls_q;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cls_q       <= '0;
      srv_q       <= '0;
      disp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
      srv_q   <= srv_d;
      disp_q  <= disp_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    if (out_load) begin
      res_kind_q <= res_kind_d;
      res_acc_q  <= res_acc_d;
      res_disp_q <= res_disp_d;
      res_cls_q  <= res_cls_d;
      res_srv_q  <= res_srv_d;
      res_tag_q  <= res_tag_d;
      res_fin_q  <= res_fin_d;
      res_last_q <= res_last_d;
    end
  end

  pcfd_queues u_queues (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .stat_o (q_stat)
  );

  pcfd_servers u_servers (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (srv_ctrl),
    .scan_idx_i (srv_q[SRV_IDX_W-1:0]),
    .dur_i      (q_stat.head[ENTRY_W-1:TAG_W]),
    .free_o     (srv_free),
    .fin_o      (fin_calc)
  );

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = res_kind_q;
  assign accepted_o       = res_acc_q;
  assign dispatched_o     = res_disp_q;
  assign class_index_o    = res_cls_q;
  assign server_index_o   = res_srv_q;
  assign dispatched_tag_o = res_tag_q;
  assign finish_time_o    = res_fin_q;
  assign last_o           = res_last_q;

  a_disp_is_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dispatched_o |-> (result_kind_o == RES_REPORT) && !accepted_o)
    else $error("dispatch flag on a non-report word");

  a_ack_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RES_ACK) |-> last_o && !dispatched_o)
    else $error("malformed enqueue acknowledgement");

  a_fin_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> srv_free && !scan_end)
    else $error("finish computed for a busy or inactive server");

  a_emit_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && slot_free && last_cls |=> (state_q == ST_IDLE))
    else $error("tick did not end after the last class");

endmodule

### dv/tb.sv
// Self-checking testbench for the per-class first-free dispatcher.
module tb import pcfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 20;

  // One queued request as the predictor holds it
  typedef struct packed {
    logic [DUR_W-1:0] dur;
    logic [TAG_W-1:0] tag;
  } request_t;

  // One result word, field for field
  typedef struct packed {
    logic                 kind;
    logic                 acc;
    logic                 disp;
    logic [CLS_W-1:0]     cls;
    logic [SRV_OUT_W-1:0] srv;
    logic [TAG_W-1:0]     tag;
    logic [TIME_W-1:0]    fin;
    logic                 last;
  } report_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [ACT_W-1:0]     cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 operation_i    = OP_ENQ;
  logic [CLS_W-1:0]     job_type_i     = '0;
  logic [DUR_W-1:0]     duration_i     = '0;
  logic [TAG_W-1:0]     request_tag_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic                 result_kind_o;
  logic                 accepted_o;
  logic                 dispatched_o;
  logic [CLS_W-1:0]     class_index_o;
  logic [SRV_OUT_W-1:0] server_index_o;
  logic [TAG_W-1:0]     dispatched_tag_o;
  logic [TIME_W-1:0]    finish_time_o;
  logic                 last_o;

  // Predictor state
  request_t          class_queue[NUM_CLASSES][$];
  logic [TIME_W-1:0] server_busy_until[MAX_SERVERS];
  logic [TIME_W-1:0] tick_count;
  logic [ACT_W-1:0]  server_count;
  report_t           pending_words[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;

  per_class_first_free_dispatch dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Work out the words one accepted input word causes
  function automatic void predict_word(logic op, logic [CLS_W-1:0] cls,
                                       logic [DUR_W-1:0] dur, logic [TAG_W-1:0] tag);
    report_t  word;
    request_t head;
    longint   fin;
    int       n_srv;
    bit       done;
    if (op == OP_ENQ) begin
      word      = '0;
      word.kind = RES_ACK;
      word.cls  = cls;
      word.tag  = tag;
      word.last = 1'b1;
      if (cls < NUM_CLASSES && class_queue[cls].size() < QUEUE_DEPTH) begin
        class_queue[cls].push_back({dur, tag});
        word.acc = 1'b1;
      end
      pending_words.push_back(word);
    end else begin
      n_srv = (server_count > MAX_SERVERS) ? MAX_SERVERS : int'(server_count);
      for (int c = 0; c < NUM_CLASSES; c++) begin
        word      = '0;
        word.kind = RES_REPORT;
        word.cls  = CLS_W'(c);
        word.last = (c == NUM_CLASSES - 1);
        done      = 1'b0;
        if (class_queue[c].size() != 0) begin
          // first free server in ascending order
          for (int s = 0; s < n_srv && !done; s++) begin
            if (server_busy_until[s] <= tick_count) begin
              head = class_queue[c].pop_front();
              fin  = longint'(tick_count) + longint'(head.dur) - 1;
              if (fin < 0) fin = 0;
              if (fin > 64'sd4294967295) fin = 64'sd4294967295;
              server_busy_until[s] = fin[TIME_W-1:0];
              word.disp = 1'b1;
              word.srv  = SRV_OUT_W'(s);
              word.tag  = head.tag;
              word.fin  = fin[TIME_W-1:0];
              done      = 1'b1;
            end
          end
        end
        pending_words.push_back(word);
      end
      if (tick_count != '1) tick_count++;
    end
  endfunction

  function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                      logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare one taken result word with the oldest expectation
  function automatic void check_word();
    report_t want;
    if (pending_words.size() == 0) begin
      $error("result word with nothing expected");
      error_count++;
    end else begin
      want = pending_words.pop_front();
      check_field("result_kind", TIME_W'(want.kind), TIME_W'(result_kind_o));
      check_field("accepted", TIME_W'(want.acc), TIME_W'(accepted_o));
      check_field("dispatched", TIME_W'(want.disp), TIME_W'(dispatched_o));
      check_field("class_index", TIME_W'(want.cls), TIME_W'(class_index_o));
      check_field("server_index", TIME_W'(want.srv), TIME_W'(server_index_o));
      check_field("dispatched_tag", TIME_W'(want.tag), TIME_W'(dispatched_tag_o));
      check_field("finish_time", want.fin, finish_time_o);
      check_field("last", TIME_W'(want.last), TIME_W'(last_o));
    end
  endfunction

  // Receiver: take and check words, random stall, watchdog on inactivity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_word();
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one word, hold it until taken, then predict
  task automatic send_word(logic op, logic [CLS_W-1:0] cls, logic [DUR_W-1:0] dur,
                           logic [TAG_W-1:0] tag);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    job_type_i    <= cls;
    duration_i    <= dur;
    request_tag_i <= tag;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(op, cls, dur, tag);
  endtask

  // Stop sending and let every expected word arrive
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_server_count(logic [ACT_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    server_count  = value;
  endtask

  task automatic send_random_word();
    logic             op;
    logic [CLS_W-1:0] cls;
    logic [DUR_W-1:0] dur;
    logic [TAG_W-1:0] tag;
    int               pick;
    op   = ($urandom_range(99) < 45) ? OP_TICK : OP_ENQ;
    cls  = ($urandom_range(99) < 5) ? CLS_W'(NUM_CLASSES)
                                    : CLS_W'($urandom_range(NUM_CLASSES - 1));
    pick = $urandom_range(99);
    if (pick < 75)      dur = DUR_W'($urandom_range(7));
    else if (pick < 95) dur = DUR_W'($urandom_range(300, 8));
    else                dur = DUR_W'($urandom);
    tag  = TAG_W'($urandom);
    send_word(op, cls, dur, tag);
  endtask

  // Reset settings: zero and full-scale durations, tags, dropped class, ignored tick fields
  task automatic test_reset_behaviour();
    send_word(OP_ENQ, 2'd0, 16'h0000, 16'h0000);  // duration 0 at time 0 clamps to 0
    send_word(OP_ENQ, 2'd1, 16'hFFFF, 16'hFFFF);
    send_word(OP_ENQ, 2'd2, 16'h0001, 16'hA5A5);
    send_word(OP_ENQ, CLS_W'(NUM_CLASSES), 16'h1234, 16'h5A5A);
    send_word(OP_TICK, CLS_W'(NUM_CLASSES), 16'hFFFF, 16'hFFFF);
    send_word(OP_TICK, 2'd0, 16'h0000, 16'h0000);
  endtask

  // No server, one busy server, full count and saturated count
  task automatic test_server_limits();
    set_server_count(5'd0);
    send_word(OP_ENQ, 2'd1, 16'd5, 16'h0101);
    send_word(OP_TICK, 2'd0, 16'd0, 16'd0);
    set_server_count(5'd1);
    send_word(OP_TICK, 2'd2, 16'd9, 16'h00FF);
    set_server_count(5'd16);
    send_word(OP_TICK, 2'd1, 16'd3, 16'hFF00);
    set_server_count(5'd31);
    send_word(OP_ENQ, 2'd0, 16'd2, 16'h0F0F);
    send_word(OP_ENQ, 2'd1, 16'd2, 16'hF0F0);
    send_word(OP_ENQ, 2'd2, 16'd2, 16'h3C3C);
    send_word(OP_TICK, 2'd0, 16'd0, 16'd0);
    send_word(OP_TICK, 2'd0, 16'd0, 16'd0);
  endtask

  // Fill one queue to the brim, then one more word is dropped
  task automatic test_queue_full();
    logic [CLS_W-1:0] cls;
    set_server_count(5'd16);
    cls = CLS_W'($urandom_range(NUM_CLASSES - 1));
    repeat (QUEUE_DEPTH + 1)
      send_word(OP_ENQ, cls, DUR_W'($urandom_range(6)), TAG_W'($urandom));
  endtask

  // Random traffic over three server settings
  task automatic test_random(int count, int spct, int rpct);
    logic [ACT_W-1:0] choices[8] = '{5'd1, 5'd2, 5'd3, 5'd10, 5'd16, 5'd17, 5'd31, 5'd0};
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    for (int chunk = 0; chunk < 3; chunk++) begin
      if ($urandom_range(3) == 0) set_server_count(ACT_W'($urandom_range(16, 1)));
      else set_server_count(choices[3'($urandom_range(7))]);
      repeat (count / 3) send_random_word();
    end
  endtask

  initial begin
    foreach (server_busy_until[s]) server_busy_until[s] = '0;
    tick_count    = '0;
    server_count  = ACT_RESET;
    send_idle_pct = 28;
    recv_idle_pct = 70;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_behaviour();
    test_server_limits();
    test_queue_full();
    test_random(105, 28, 70);
    test_random(105, 70, 28);
    test_random(105, 0, 0);

    wait_idle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

### files.f
rtl/core/pcfd_pkg.sv
rtl/core/pcfd_ram.sv
rtl/core/pcfd_queues.sv
rtl/core/pcfd_servers.sv
rtl/core/per_class_first_free_dispatch.sv
dv/tb.sv
